FILE: rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the sensor sweep averager: field widths,
// register indexes and the microcode program of the control sequencer.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int SAMPLE_W   = 16;  // ADC sample port
  localparam int VALUE_W    = 16;  // result value
  localparam int SENSOR_W   = 4;   // sensor index
  localparam int SUM_W      = 24;  // accumulator, holds 255 full-scale samples
  localparam int CNT_W      = 8;   // sample counter / samples per sensor
  localparam int DIV_STEPS  = 24;  // one quotient bit per step
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 1'b1;

  // microcode addresses
  typedef enum logic [2:0] {
    UP_FETCH,   // wait for a sample transfer
    UP_ACC,     // accumulate, count, dispatch
    UP_DDIV,    // start dark mean division
    UP_DWAIT,   // store dark mean
    UP_LDIV,    // start final mean division
    UP_LWAIT    // build the result
  } upc_t;

  typedef enum logic [2:0] {
    J_GOTO,      // unconditional
    J_ACCEPT,    // hold until a sample is taken
    J_DISPATCH,  // dark close / sensor end / back to fetch
    J_DIV_END,   // hold until divider done, then end or fetch
    J_DIV_OUT    // hold until divider done and result slot free
  } jmp_t;

  typedef struct packed {
    logic in_rdy;
    logic acc;
    logic div_go;
    logic div_lit;  // 1: final window divisor, 0: dark window divisor
    logic wr_dark;
    logic wr_out;
    jmp_t jmp;
    upc_t tgt;
  } uword_t;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '0;
    case (pc)
      UP_FETCH: begin
        w.in_rdy = 1'b1;
        w.jmp    = J_ACCEPT;
        w.tgt    = UP_ACC;
      end
      UP_ACC: begin
        w.acc = 1'b1;
        w.jmp = J_DISPATCH;
        w.tgt = UP_DDIV;
      end
      UP_DDIV: begin
        w.div_go = 1'b1;
        w.jmp    = J_GOTO;
        w.tgt    = UP_DWAIT;
      end
      UP_DWAIT: begin
        w.wr_dark = 1'b1;
        w.jmp     = J_DIV_END;
        w.tgt     = UP_LDIV;
      end
      UP_LDIV: begin
        w.div_go  = 1'b1;
        w.div_lit = 1'b1;
        w.jmp     = J_GOTO;
        w.tgt     = UP_LWAIT;
      end
      UP_LWAIT: begin
        w.div_lit = 1'b1;
        w.wr_out  = 1'b1;
        w.jmp     = J_DIV_OUT;
        w.tgt     = UP_FETCH;
      end
      default: begin
        w.jmp = J_GOTO;
        w.tgt = UP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/ssa_div.sv
// ----------------------------------------------------------------------------
// ssa_div
// Restoring divider, one quotient bit per cycle. Divides the accumulator
// by an 8-bit count. done stays high from completion until the next start.
// ----------------------------------------------------------------------------
module ssa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ssa_pkg::SUM_W-1:0] dividend,
  input  logic [ssa_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [ssa_pkg::SUM_W-1:0] quotient
);
  import ssa_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // when not ge the shifted remainder is below the divisor, so it fits
      rem_nxt  = ge ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/sensor_sweep_averager_top.sv
// ----------------------------------------------------------------------------
// sensor_sweep_averager_top
// Averages ADC samples per multiplexed sensor, optionally as lit minus dark.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one ADC sample per transfer (valid/ready). Sensors are swept
//           0 .. SENSOR_COUNT-1; each gets samples_per_sensor samples.
//   out_* : one result per sensor, sent on the sensor's last sample.
//   cfg_* : write-only registers, 0 samples_per_sensor, 1 offset_mode.
//           Write only while no sample is in flight.
// Control: runs from a six-step microcode table. A sample that closes no
//   window passes through fetch and accumulate only. Each mean goes through
//   one shared 24-step restoring divider; a sample that closes the dark
//   window, or a sensor's last sample, also waits for its division.
//   out_valid rises when the final mean is written to the output register.
// Reset: all counters, sums and the sweep position clear; samples_per_sensor
//   returns to 128 and offset_mode to 0.
// Stall: the result sits in an output register; the next sensor's samples
//   keep flowing. Apart from waiting on the divider, the sequencer holds only
//   when a new result is ready while the old one is not yet taken, and in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module sensor_sweep_averager_top #(
  parameter int SENSOR_COUNT  = 15,
  parameter int DISCARD_COUNT = 1,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ssa_pkg::SAMPLE_W-1:0]          in_adc_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ssa_pkg::SENSOR_W-1:0]          out_sensor_number,
  output logic signed [ssa_pkg::VALUE_W-1:0]    out_sensor_value,
  output logic                                  out_divisor_error,
  output logic                                  out_sweep_last
);
  import ssa_pkg::*;

  localparam logic [CNT_W-1:0] DISC = CNT_W'(DISCARD_COUNT);
  localparam logic [SAMPLE_W-1:0] SMASK =
      (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [SENSOR_W:0] SENSOR_END = (SENSOR_W + 1)'(SENSOR_COUNT);

  // registers
  logic [CNT_W-1:0]    cfg_samples_r, cfg_samples_nxt;
  logic                cfg_offset_r, cfg_offset_nxt;
  upc_t                upc_r, upc_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic                off_r, off_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SENSOR_W-1:0] sensor_r, sensor_nxt;
  logic                lit_r, lit_nxt;
  logic [VALUE_W-1:0]  dark_r, dark_nxt;  // low bits of dark mean are all that matter
  logic                end_r, end_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SENSOR_W-1:0] out_num_r, out_num_nxt;
  logic [VALUE_W-1:0]  out_val_r, out_val_nxt;
  logic                out_err_r, out_err_nxt;
  logic                out_last_r, out_last_nxt;

  // datapath
  uword_t              uw;
  logic [CNT_W-1:0]    half;
  logic [CNT_W-1:0]    pos;
  logic                keep;
  logic [SUM_W-1:0]    sum_acc;
  logic                close_dark;
  logic                last_smp;
  logic                dark_dz;
  logic [CNT_W-1:0]    tot;
  logic                fin_err;
  logic                xfer_in;
  logic                slot_free;
  logic                wrap;
  logic [CNT_W-1:0]    div_dvs;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic [VALUE_W-1:0]  mean16;

  assign uw = ucode(upc_r);

  assign half     = {1'b0, n_r[CNT_W-1:1]};
  assign pos      = (off_r && lit_r) ? ((count_r >= half) ? count_r - half : '0) : count_r;
  assign keep     = pos >= DISC;
  assign sum_acc  = sum_r + (keep ? SUM_W'(sample_r) : '0);
  assign close_dark = off_r && !lit_r && (half != '0) && (count_r >= half - 1'b1);
  assign last_smp = ({1'b0, count_r} + 1'b1) >= {1'b0, n_r};
  assign dark_dz  = half <= DISC;
  assign tot      = off_r ? n_r - half : n_r;
  assign fin_err  = (tot <= DISC) || (off_r && (!lit_r || dark_dz));
  assign div_dvs  = uw.div_lit ? tot - DISC : half - DISC;
  assign xfer_in  = in_valid && uw.in_rdy;
  assign slot_free = !out_valid_r || out_ready;
  assign wrap     = ({1'b0, sensor_r} + 1'b1) >= SENSOR_END;
  assign mean16   = div_quo[VALUE_W-1:0];

  ssa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (uw.div_go),
    .dividend (sum_r),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    case (uw.jmp)
      J_GOTO:     upc_nxt = uw.tgt;
      J_ACCEPT:   upc_nxt = xfer_in ? uw.tgt : upc_r;
      J_DISPATCH: upc_nxt = close_dark ? uw.tgt : (last_smp ? UP_LDIV : UP_FETCH);
      J_DIV_END:  upc_nxt = div_done ? (end_r ? uw.tgt : UP_FETCH) : upc_r;
      J_DIV_OUT:  upc_nxt = (div_done && slot_free) ? uw.tgt : upc_r;
      default:    upc_nxt = UP_FETCH;
    endcase
  end

  // datapath updates
  always_comb begin
    cfg_samples_nxt = cfg_samples_r;
    cfg_offset_nxt  = cfg_offset_r;
    sample_nxt      = sample_r;
    n_nxt           = n_r;
    off_nxt         = off_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    sensor_nxt      = sensor_r;
    lit_nxt         = lit_r;
    dark_nxt        = dark_r;
    end_nxt         = end_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_num_nxt     = out_num_r;
    out_val_nxt     = out_val_r;
    out_err_nxt     = out_err_r;
    out_last_nxt    = out_last_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SAMPLES: cfg_samples_nxt = cfg_data[CNT_W-1:0];
        REG_OFFSET:  cfg_offset_nxt  = cfg_data[0];
        default:     ;
      endcase
    end

    // config is sampled with the transfer; a length of 0 acts as 1
    if (xfer_in) begin
      sample_nxt = in_adc_sample & SMASK;
      n_nxt      = (cfg_samples_r == '0) ? CNT_W'(1) : cfg_samples_r;
      off_nxt    = cfg_offset_r;
    end

    if (uw.acc) begin
      sum_nxt = sum_acc;
      end_nxt = last_smp;
      if (!last_smp) begin
        count_nxt = count_r + 1'b1;
      end
    end

    if (uw.wr_dark && div_done) begin
      dark_nxt = dark_dz ? '0 : mean16;
      sum_nxt  = '0;
      lit_nxt  = 1'b1;
    end

    if (uw.wr_out && div_done && slot_free) begin
      out_valid_nxt = 1'b1;
      out_num_nxt   = sensor_r;
      out_err_nxt   = fin_err;
      out_val_nxt   = fin_err ? '0 : (off_r ? mean16 - dark_r : mean16);
      out_last_nxt  = wrap;
      sensor_nxt    = wrap ? '0 : sensor_r + 1'b1;
      sum_nxt       = '0;
      count_nxt     = '0;
      lit_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_samples_r <= CNT_W'(128);
      cfg_offset_r  <= 1'b0;
      upc_r         <= UP_FETCH;
      sum_r         <= '0;
      count_r       <= '0;
      sensor_r      <= '0;
      lit_r         <= 1'b0;
      end_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cfg_samples_r <= cfg_samples_nxt;
      cfg_offset_r  <= cfg_offset_nxt;
      upc_r         <= upc_nxt;
      sum_r         <= sum_nxt;
      count_r       <= count_nxt;
      sensor_r      <= sensor_nxt;
      lit_r         <= lit_nxt;
      end_r         <= end_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    n_r        <= n_nxt;
    off_r      <= off_nxt;
    dark_r     <= dark_nxt;
    out_num_r  <= out_num_nxt;
    out_val_r  <= out_val_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready          = uw.in_rdy;
  assign out_valid         = out_valid_r;
  assign out_sensor_number = out_num_r;
  assign out_sensor_value  = out_val_r;
  assign out_divisor_error = out_err_r;
  assign out_sweep_last    = out_last_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_divisor_error |-> out_sensor_value == '0)
    else $error("divisor error with nonzero value");

  a_last_num: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_sweep_last |-> {1'b0, out_sensor_number} == SENSOR_END - 1'b1)
    else $error("sweep_last on wrong sensor");

  a_acc_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
      upc_r == UP_ACC |-> $past(in_valid && in_ready))
    else $error("accumulate step without a sample transfer");

  a_sensor_range: assert property (@(posedge clk) disable iff (!rst_n)
      {1'b0, sensor_r} < SENSOR_END)
    else $error("sensor index out of range");

endmodule
